/* sv/mre_pkg.sv */
// mre_pkg: shared types, constants and command/status structs of the mlp residual scorer
// used by every module of the block; no dependencies
`default_nettype none

package mre_pkg;

    localparam int FEATURES_DEF = 138;
    localparam int HIDDEN_DEF   = 32;

    localparam int STORE_AW    = 13;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    localparam int DVD_W = 64;
    localparam int DVS_W = 32;

    localparam int TANH_HALF = 128;
    localparam int POS_AW    = 8;
    localparam int POS_W     = 17;
    localparam int Z_W       = 18;
    localparam logic [25:0] TANH_STEP_Q30 = 26'd33543513;

    localparam logic [15:0] SCORE_MAX = 16'd20000;

    localparam int CFG_IW = 8;
    localparam logic [CFG_IW-1:0] CFG_SHRINK = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_BIAS   = 8'd1;

    localparam logic KIND_PARAM   = 1'b0;
    localparam logic KIND_FEATURE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [12:0]        param_address;
        logic signed [31:0] value;
        logic               last;
    } in_t;

    typedef struct packed {
        logic signed [15:0] score;
        logic               fallback;
    } out_t;

    typedef enum logic [2:0] {RS_MU, RS_SIGMA, RS_B1, RS_W1, RS_W2} rsel_t;
    typedef enum logic {MAC_W1X, MAC_W2Z} msrc_t;

    typedef struct packed {
        logic  in_ready;
        logic  tb_init;
        logic  tb_mul;
        logic  tb_load;
        logic  tb_write;
        logic  div_start;
        logic  xh_d;
        logic  xh_load;
        logic  xh_write;
        logic  j_clr;
        logic  j_inc;
        logic  h_clr;
        logic  h_inc;
        rsel_t rsel;
        logic  mac_issue;
        msrc_t msrc;
        logic  acc_clr;
        logic  acc_bias;
        logic  th_idx;
        logic  th_write;
        logic  fin_r16;
        logic  fin_mul;
        logic  fin_pre;
        logic  out_load;
        logic  out_fb;
    } cmd_t;

    typedef struct packed {
        logic last_accept;
        logic div_done;
        logic sigma_zero;
        logic xh_bad;
        logic j_last;
        logic h_last;
        logic k_last;
        logic mac_busy;
        logic acc_ovf;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* sv/mre_div.sv */
// mre_div: iterative restoring unsigned divider, one quotient bit per cycle
// depends on mre_pkg for default widths
`default_nettype none

module mre_div #(
    parameter int DVD_W = mre_pkg::DVD_W,
    parameter int DVS_W = mre_pkg::DVS_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next, dvs_reg;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [DVS_W:0]   shl, diff;
    logic             ge;

    always_comb begin
        shl      = {rem_reg, quo_reg[DVD_W-1]};
        diff     = shl - {1'b0, dvs_reg};
        ge       = shl >= {1'b0, dvs_reg};
        rem_next = ge ? diff[DVS_W-1:0] : shl[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* sv/mre_datapath.sv */
// mre_datapath: model store, feature/xhat/hidden buffers, tanh table, mac, output register
// depends on mre_pkg and mre_div
`default_nettype none

module mre_datapath #(
    parameter int FEATURES = mre_pkg::FEATURES_DEF,
    parameter int HIDDEN   = mre_pkg::HIDDEN_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire mre_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output mre_pkg::out_t                    m_data,
    input  wire logic                        cfg_valid,
    input  wire logic [mre_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [31:0]                 cfg_data,
    input  wire mre_pkg::cmd_t               cmd,
    output mre_pkg::sts_t                    sts
);
    import mre_pkg::*;

    localparam int JW = $clog2(FEATURES);
    localparam int HW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int SIGMA_BASE = FEATURES;
    localparam int B1_BASE    = 2 * FEATURES;
    localparam int W2_BASE    = 2 * FEATURES + HIDDEN;
    localparam int W1_BASE    = 2 * FEATURES + 2 * HIDDEN;
    localparam logic [JW-1:0] J_LAST = JW'(FEATURES - 1);
    localparam logic [HW-1:0] H_LAST = HW'(HIDDEN - 1);
    localparam logic signed [63:0] ACC_LIM = 64'sh2000_0000_0000_0000;

    // config
    logic [16:0]        shrink_reg;
    logic signed [31:0] bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shrink_reg <= '0;
            bias_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SHRINK: shrink_reg <= cfg_data[16:0];
                CFG_BIAS:   bias_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic s_acc;
    assign s_acc = s_valid & cmd.in_ready;

    // counters
    logic [JW-1:0]     j_reg, fcnt_reg;
    logic [HW-1:0]     h_reg;
    logic [POS_AW-1:0] k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg    <= '0;
            h_reg    <= '0;
            k_reg    <= '0;
            fcnt_reg <= '0;
        end else begin
            if (cmd.j_clr)      j_reg <= '0;
            else if (cmd.j_inc) j_reg <= j_reg + JW'(1);
            if (cmd.h_clr)      h_reg <= '0;
            else if (cmd.h_inc) h_reg <= h_reg + HW'(1);
            if (cmd.tb_init)       k_reg <= POS_AW'(1);
            else if (cmd.tb_write) k_reg <= k_reg + POS_AW'(1);
            if (s_acc && s_data.kind == KIND_FEATURE) begin
                if (s_data.last)            fcnt_reg <= '0;
                else if (fcnt_reg != J_LAST) fcnt_reg <= fcnt_reg + JW'(1);
            end
        end
    end

    // model store
    logic [31:0]           store_mem [STORE_DEPTH];
    logic signed [31:0]    store_rd_reg;
    logic [31:0]           ra_sum;

    always_comb begin
        case (cmd.rsel)
            RS_MU:    ra_sum = 32'(j_reg);
            RS_SIGMA: ra_sum = 32'(SIGMA_BASE) + 32'(j_reg);
            RS_B1:    ra_sum = 32'(B1_BASE) + 32'(h_reg);
            RS_W2:    ra_sum = 32'(W2_BASE) + 32'(h_reg);
            RS_W1:    ra_sum = 32'(W1_BASE) + 32'(h_reg) * 32'(FEATURES) + 32'(j_reg);
            default:  ra_sum = 32'(j_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.kind == KIND_PARAM)
            store_mem[s_data.param_address] <= s_data.value;
        store_rd_reg <= store_mem[ra_sum[STORE_AW-1:0]];
    end

    // feature buffer and base score
    logic [31:0]        fb_mem [FEATURES];
    logic signed [31:0] fb_rd_reg, base_reg;

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.kind == KIND_FEATURE) begin
            if (s_data.last) begin
                fb_mem[J_LAST] <= s_data.value;
                base_reg       <= s_data.value;
            end else if (fcnt_reg != J_LAST) begin
                fb_mem[fcnt_reg] <= s_data.value;
            end
        end
        fb_rd_reg <= fb_mem[j_reg];
    end

    // divider operands
    logic [DVD_W-1:0] op_dvd_reg, div_q;
    logic [DVS_W-1:0] op_dvs_reg;
    logic             div_done, neg_reg;

    mre_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (op_dvd_reg),
        .divisor  (op_dvs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // tanh table build
    logic [31:0]      t_reg;
    logic [57:0]      tprod_reg, tp_rnd;
    logic [31:0]      tb_den;
    logic [63:0]      tb_dvd;
    logic signed [32:0] d_reg;
    logic [32:0]      dmag;
    logic [31:0]      smag;

    always_comb begin
        tp_rnd = tprod_reg + 58'h2000_0000;
        tb_den = 32'h4000_0000 + 32'(tp_rnd >> 30);
        tb_dvd = ((64'(t_reg) + 64'(TANH_STEP_Q30)) << 30) + 64'(tb_den >> 1);
        dmag   = d_reg[32] ? (33'd0 - d_reg) : d_reg;
        smag   = store_rd_reg[31] ? (32'd0 - store_rd_reg) : store_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.tb_init)  t_reg <= '0;
        if (cmd.tb_write) t_reg <= div_q[31:0];
        if (cmd.tb_mul)   tprod_reg <= 58'(t_reg) * 58'(TANH_STEP_Q30);
        if (cmd.xh_d)     d_reg <= 33'(fb_rd_reg) - 33'(store_rd_reg);
        if (cmd.tb_load) begin
            op_dvd_reg <= tb_dvd;
            op_dvs_reg <= tb_den;
        end else if (cmd.xh_load) begin
            op_dvd_reg <= {15'd0, dmag, 16'd0};
            op_dvs_reg <= smag;
            neg_reg    <= d_reg[32] ^ store_rd_reg[31];
        end
    end

    // tanh table
    logic [POS_W-1:0]  pos_mem [TANH_HALF + 1];
    logic [POS_W-1:0]  p0_reg, p1_reg;
    logic [8:0]        tk_reg, tk1;
    logic [10:0]       tf_reg;
    logic [POS_AW-1:0] pa0, pa1;

    always_comb begin
        tk1 = (tk_reg == 9'd256) ? tk_reg : tk_reg + 9'd1;
        pa0 = (tk_reg >= 9'd128) ? POS_AW'(tk_reg - 9'd128) : POS_AW'(9'd128 - tk_reg);
        pa1 = (tk1 >= 9'd128) ? POS_AW'(tk1 - 9'd128) : POS_AW'(9'd128 - tk1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.tb_init)
            pos_mem[0] <= '0;
        else if (cmd.tb_write)
            pos_mem[k_reg] <= POS_W'((div_q + 64'd8192) >> 14);
        p0_reg <= pos_mem[pa0];
        p1_reg <= pos_mem[pa1];
    end

    // xhat and hidden buffers
    logic [31:0]           xh_mem [FEATURES];
    logic signed [31:0]    xh_rd_reg;
    logic [Z_W-1:0]        hid_mem [HIDDEN];
    logic signed [Z_W-1:0] hid_rd_reg;
    logic [31:0]           xq;
    logic signed [Z_W-1:0] t0, t1, z;
    logic signed [Z_W:0]   dd;
    logic signed [30:0]    mz;

    always_comb begin
        xq = div_q[31:0];
        t0 = (tk_reg < 9'd128) ? -$signed({1'b0, p0_reg}) : $signed({1'b0, p0_reg});
        t1 = (tk1 < 9'd128) ? -$signed({1'b0, p1_reg}) : $signed({1'b0, p1_reg});
        dd = (Z_W+1)'(t1) - (Z_W+1)'(t0);
        mz = 31'(dd) * 31'($signed({1'b0, tf_reg}));
        z  = t0 + Z_W'(mz >>> 11);
    end

    always_ff @(posedge aclk) begin
        if (cmd.xh_write)
            xh_mem[j_reg] <= neg_reg ? (~xq + 32'd1) : xq;
        xh_rd_reg <= xh_mem[j_reg];
        if (cmd.th_write)
            hid_mem[h_reg] <= z;
        hid_rd_reg <= hid_mem[h_reg];
    end

    // mac pipeline
    logic               v1_reg, v2_reg;
    msrc_t              src1_reg;
    logic signed [31:0] opnd;
    logic signed [63:0] prod_reg, acc_reg, acc_sum;
    logic               ovf_reg;

    always_comb begin
        opnd    = (src1_reg == MAC_W2Z) ? 32'(hid_rd_reg) : xh_rd_reg;
        acc_sum = acc_reg + prod_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ovf_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
            if (cmd.acc_clr)
                ovf_reg <= 1'b0;
            else if (v2_reg && (acc_sum > ACC_LIM || acc_sum < -ACC_LIM))
                ovf_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        src1_reg <= cmd.msrc;
        if (v1_reg)
            prod_reg <= 64'(store_rd_reg) * 64'(opnd);
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_bias)
            acc_reg <= 64'(bias_reg) <<< 16;
        else if (v2_reg)
            acc_reg <= acc_sum;
    end

    // tanh index from hidden sum
    logic signed [63:0] acc_rnd, th_pre, th_off;

    always_comb begin
        acc_rnd = acc_reg + 64'sd32768;
        th_pre  = (acc_rnd >>> 16) + 64'(store_rd_reg);
        th_off  = th_pre + 64'sd262144;
    end

    always_ff @(posedge aclk) begin
        if (cmd.th_idx) begin
            if (th_off <= 64'sd0) begin
                tk_reg <= 9'd0;
                tf_reg <= '0;
            end else if (th_off >= 64'sd524288) begin
                tk_reg <= 9'd256;
                tf_reg <= '0;
            end else begin
                tk_reg <= {1'b0, th_off[18:11]};
                tf_reg <= th_off[10:0];
            end
        end
    end

    // final scaling
    logic signed [47:0] r16_reg;
    logic signed [63:0] mul_reg, pre_reg;
    logic [16:0]        sh;
    logic [63:0]        pmag, prnd;
    logic [15:0]        pcl, bcl;
    logic [32:0]        bmag;
    logic signed [15:0] ev_score, fb_score;

    always_comb begin
        sh       = (shrink_reg > 17'd65536) ? 17'd65536 : shrink_reg;
        pmag     = pre_reg[63] ? (64'd0 - pre_reg) : pre_reg;
        prnd     = (pmag + 64'h8000_0000) >> 32;
        pcl      = (prnd > 64'(SCORE_MAX)) ? SCORE_MAX : prnd[15:0];
        ev_score = pre_reg[63] ? -$signed(pcl) : $signed(pcl);
        bmag     = base_reg[31] ? (33'd0 - {1'b1, base_reg}) : {1'b0, base_reg};
        bcl      = (bmag[32:16] > 17'(SCORE_MAX)) ? SCORE_MAX : bmag[31:16];
        fb_score = base_reg[31] ? -$signed(bcl) : $signed(bcl);
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_r16) r16_reg <= 48'(acc_rnd >>> 16);
        if (cmd.fin_mul) mul_reg <= 64'(r16_reg) * 64'($signed({1'b0, sh}));
        if (cmd.fin_pre) pre_reg <= (64'(base_reg) <<< 16) + mul_reg;
    end

    // output register
    logic m_valid_reg;
    out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (cmd.out_load)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.score    <= cmd.out_fb ? fb_score : ev_score;
            m_data_reg.fallback <= cmd.out_fb;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sts.last_accept = s_acc && s_data.kind == KIND_FEATURE && s_data.last;
        sts.div_done    = div_done;
        sts.sigma_zero  = store_rd_reg == 32'sd0;
        sts.xh_bad      = neg_reg ? (div_q > 64'h8000_0000) : (div_q > 64'h7FFF_FFFF);
        sts.j_last      = j_reg == J_LAST;
        sts.h_last      = h_reg == H_LAST;
        sts.k_last      = k_reg == POS_AW'(TANH_HALF);
        sts.mac_busy    = v1_reg | v2_reg;
        sts.acc_ovf     = ovf_reg;
        sts.out_free    = !m_valid_reg || m_ready;
    end

endmodule

`default_nettype wire

/* sv/mre_ctrl.sv */
// mre_ctrl: sequencer for table build, normalization, hidden layer, output layer and result
// depends on mre_pkg
`default_nettype none

module mre_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire mre_pkg::sts_t sts,
    output mre_pkg::cmd_t      cmd
);
    import mre_pkg::*;

    typedef enum logic [4:0] {
        ST_TB_INIT, ST_TB_MUL, ST_TB_LOAD, ST_TB_GO, ST_TB_WAIT, ST_TB_WR,
        ST_IDLE,
        ST_X_MU, ST_X_SG, ST_X_CHK, ST_X_GO, ST_X_WAIT, ST_X_WR,
        ST_H_ISSUE, ST_H_DRAIN, ST_TH_B1, ST_TH_K, ST_TH_RD, ST_TH_Z,
        ST_P3_INIT, ST_P3_ISSUE, ST_P3_DRAIN,
        ST_FIN_R16, ST_FIN_MUL, ST_FIN_PRE, ST_FIN_OUT, ST_FAIL
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_TB_INIT;
        else
            state_reg <= state_next;
    end

    always_comb begin
        cmd        = '0;
        cmd.rsel   = RS_MU;
        cmd.msrc   = MAC_W1X;
        state_next = state_reg;
        case (state_reg)
            ST_TB_INIT: begin
                cmd.tb_init = 1'b1;
                state_next  = ST_TB_MUL;
            end
            ST_TB_MUL: begin
                cmd.tb_mul = 1'b1;
                state_next = ST_TB_LOAD;
            end
            ST_TB_LOAD: begin
                cmd.tb_load = 1'b1;
                state_next  = ST_TB_GO;
            end
            ST_TB_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_TB_WAIT;
            end
            ST_TB_WAIT: begin
                if (sts.div_done) state_next = ST_TB_WR;
            end
            ST_TB_WR: begin
                cmd.tb_write = 1'b1;
                state_next   = sts.k_last ? ST_IDLE : ST_TB_MUL;
            end
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.j_clr    = 1'b1;
                if (sts.last_accept) state_next = ST_X_MU;
            end
            ST_X_MU: begin
                cmd.rsel   = RS_MU;
                state_next = ST_X_SG;
            end
            ST_X_SG: begin
                cmd.xh_d   = 1'b1;
                cmd.rsel   = RS_SIGMA;
                state_next = ST_X_CHK;
            end
            ST_X_CHK: begin
                if (sts.sigma_zero) begin
                    state_next = ST_FAIL;
                end else begin
                    cmd.xh_load = 1'b1;
                    state_next  = ST_X_GO;
                end
            end
            ST_X_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_X_WAIT;
            end
            ST_X_WAIT: begin
                if (sts.div_done) state_next = ST_X_WR;
            end
            ST_X_WR: begin
                if (sts.xh_bad) begin
                    state_next = ST_FAIL;
                end else begin
                    cmd.xh_write = 1'b1;
                    if (sts.j_last) begin
                        cmd.j_clr   = 1'b1;
                        cmd.h_clr   = 1'b1;
                        cmd.acc_clr = 1'b1;
                        state_next  = ST_H_ISSUE;
                    end else begin
                        cmd.j_inc  = 1'b1;
                        state_next = ST_X_MU;
                    end
                end
            end
            ST_H_ISSUE: begin
                cmd.rsel      = RS_W1;
                cmd.mac_issue = 1'b1;
                cmd.msrc      = MAC_W1X;
                if (sts.j_last) state_next = ST_H_DRAIN;
                else            cmd.j_inc  = 1'b1;
            end
            ST_H_DRAIN: begin
                if (!sts.mac_busy)
                    state_next = sts.acc_ovf ? ST_FAIL : ST_TH_B1;
            end
            ST_TH_B1: begin
                cmd.rsel   = RS_B1;
                state_next = ST_TH_K;
            end
            ST_TH_K: begin
                cmd.th_idx = 1'b1;
                state_next = ST_TH_RD;
            end
            ST_TH_RD: begin
                state_next = ST_TH_Z;
            end
            ST_TH_Z: begin
                cmd.th_write = 1'b1;
                if (sts.h_last) begin
                    state_next = ST_P3_INIT;
                end else begin
                    cmd.h_inc   = 1'b1;
                    cmd.j_clr   = 1'b1;
                    cmd.acc_clr = 1'b1;
                    state_next  = ST_H_ISSUE;
                end
            end
            ST_P3_INIT: begin
                cmd.acc_bias = 1'b1;
                cmd.h_clr    = 1'b1;
                state_next   = ST_P3_ISSUE;
            end
            ST_P3_ISSUE: begin
                cmd.rsel      = RS_W2;
                cmd.mac_issue = 1'b1;
                cmd.msrc      = MAC_W2Z;
                if (sts.h_last) state_next = ST_P3_DRAIN;
                else            cmd.h_inc  = 1'b1;
            end
            ST_P3_DRAIN: begin
                cmd.msrc = MAC_W2Z;
                if (!sts.mac_busy) state_next = ST_FIN_R16;
            end
            ST_FIN_R16: begin
                cmd.fin_r16 = 1'b1;
                state_next  = ST_FIN_MUL;
            end
            ST_FIN_MUL: begin
                cmd.fin_mul = 1'b1;
                state_next  = ST_FIN_PRE;
            end
            ST_FIN_PRE: begin
                cmd.fin_pre = 1'b1;
                state_next  = ST_FIN_OUT;
            end
            ST_FIN_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FAIL: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_fb   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* sv/mlp_residual_score_evaluator_top.sv */
// mlp_residual_score_evaluator_top: two-layer mlp residual scorer, signed q16.16
// depends on mre_pkg, mre_ctrl, mre_datapath (which holds mre_div)
//
//   channel  ports                        word
//   input    s_valid s_ready s_data       in_t: kind, param_address, value, last
//   result   m_valid m_ready m_data       out_t: score, fallback
//   config   cfg_valid cfg_ready          cfg_index, cfg_data (0 shrink_gain, 1 output_bias)
//
// parameter and non-last feature words are taken back to back while the block is idle
// a last feature starts a scoring run whose length is set by the shared divider
// per feature and the single mac port per product
// after reset the tanh table is built with the same divider, with s_ready low
// words are taken while a result waits in the output register; config is always ready
`default_nettype none

module mlp_residual_score_evaluator_top #(
    parameter int FEATURES = mre_pkg::FEATURES_DEF,
    parameter int HIDDEN   = mre_pkg::HIDDEN_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire mre_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output mre_pkg::out_t                    m_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mre_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [31:0]                 cfg_data
);
    import mre_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    mre_datapath #(.FEATURES(FEATURES), .HIDDEN(HIDDEN)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign s_ready   = cmd.in_ready;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
